/* rtl/hslc_pkg.sv */
// Shared types, constants and the hue sector decode for the HSL to RGB converter.
// Used by hslc_chan and hsl_to_rgb_converter; depends on nothing else.
package hslc_pkg;

  typedef struct packed {
    logic [23:0] hue;
    logic [15:0] saturation;
    logic [15:0] luminance;
  } hsl_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  // Sixty-degree hue sectors, named by the channel that ramps within them.
  typedef enum logic [2:0] {
    SEC_GREEN_UP   = 3'd0,
    SEC_RED_DOWN   = 3'd1,
    SEC_BLUE_UP    = 3'd2,
    SEC_GREEN_DOWN = 3'd3,
    SEC_RED_UP     = 3'd4,
    SEC_BLUE_DOWN  = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t    sector;
    logic [3:0] rem;
  } hue_pos_t;

  // The hue above its 10 low bits counts 4-degree steps: 90 per turn, 15 per sector.
  localparam logic [6:0]  HUE_STEPS_TURN  = 7'd90;
  localparam logic [13:0] HUE_STEPS_TURN_W = 14'd90;
  localparam logic [3:0]  HUE_STEPS_SECTOR = 4'd15;
  // ceil(2^24 / 90): exact floor division for any 14-bit step count.
  localparam logic [17:0] HUE_RECIP_TURN  = 18'd186414;
  localparam logic [15:0] HALF_LUM        = 16'h8000;

  function automatic hue_pos_t hue_split(input logic [6:0] steps);
    hue_pos_t p;
    if (steps >= 7'd75) begin
      p.sector = SEC_BLUE_DOWN;
      p.rem    = 4'(steps - 7'd75);
    end else if (steps >= 7'd60) begin
      p.sector = SEC_RED_UP;
      p.rem    = 4'(steps - 7'd60);
    end else if (steps >= 7'd45) begin
      p.sector = SEC_GREEN_DOWN;
      p.rem    = 4'(steps - 7'd45);
    end else if (steps >= 7'd30) begin
      p.sector = SEC_BLUE_UP;
      p.rem    = 4'(steps - 7'd30);
    end else if (steps >= 7'({3'b0, HUE_STEPS_SECTOR})) begin
      p.sector = SEC_RED_DOWN;
      p.rem    = 4'(steps - 7'({3'b0, HUE_STEPS_SECTOR}));
    end else begin
      p.sector = SEC_GREEN_UP;
      p.rem    = steps[3:0];
    end
    return p;
  endfunction

endpackage

/* rtl/hslc_chan.sv */
// One color channel of the HSL to RGB converter: darken or lighten the ramp value,
// then blend with grey by saturation and round. Uses hslc_pkg.
module hslc_chan #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [3:0]           en,
  input  logic [FRAC_BITS:0]   ramp,
  input  logic [15:0]          saturation,
  input  logic [15:0]          luminance,
  output logic [15:0]          level
);

  localparam int CW = FRAC_BITS + 1;
  localparam int PW = CW + 16;
  localparam int AW = 50;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic            dark;
  logic [15:0]     lum_diff;
  logic [15:0]     lift;
  logic [CW-1:0]   mul_a;
  logic [15:0]     mul_b;
  logic [16:0]     inv_sat;
  logic [32:0]     grey_full;

  logic            dark_a;
  logic [CW-1:0]   ramp_a;
  logic [PW-1:0]   prod_a;
  logic [15:0]     sat_a;
  logic [31:0]     grey_a;

  logic [CW-1:0]   mixed;
  logic [CW-1:0]   mixed_b;
  logic [15:0]     sat_b;
  logic [31:0]     grey_b;

  logic [PW-1:0]   pv_c;
  logic [31:0]     grey_c;

  logic [AW-1:0]   acc;
  logic [17:0]     rounded;

  // Darkening scales the ramp by twice the luminance; lightening moves it toward
  // one by twice the luminance above one half. Both share one multiplier.
  always_comb begin
    dark      = luminance <= hslc_pkg::HALF_LUM;
    lum_diff  = luminance - hslc_pkg::HALF_LUM;
    lift      = {lum_diff[14:0], 1'b0};
    mul_a     = dark ? ramp : ONE - ramp;
    mul_b     = dark ? luminance : lift;
    inv_sat   = 17'h10000 - {1'b0, saturation};
    grey_full = {17'b0, luminance} * {16'b0, inv_sat};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dark_a <= dark;
      ramp_a <= ramp;
      prod_a <= PW'(mul_a) * PW'(mul_b);
      sat_a  <= saturation;
      grey_a <= grey_full[31:0];
    end
  end

  assign mixed = dark_a ? prod_a[15 +: CW] : ramp_a + prod_a[16 +: CW];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mixed_b <= mixed;
      sat_b   <= sat_a;
      grey_b  <= grey_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pv_c   <= PW'(mixed_b) * PW'(sat_b);
      grey_c <= grey_b;
    end
  end

  always_comb begin
    acc = AW'({pv_c, {(32 - FRAC_BITS){1'b0}}}) + AW'({grey_c, 16'b0})
        + (AW'(1) << 31);
    rounded = acc[AW-1:32];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      level <= (rounded[17:16] != 2'b00) ? 16'hFFFF : rounded[15:0];
    end
  end

endmodule

/* rtl/hsl_to_rgb_converter.sv */
// Top level of the HSL to RGB converter: hue decode stages, pipeline control and
// the three channel pipelines. Uses hslc_pkg and hslc_chan.
//
// The converter takes one pixel per clock while hsl_stall is low.
// It is a seven-stage pipeline (hue wrap, sector split, fraction multiply, ramp
// scale, lighten add, saturation multiply, blend and round), each stage holding a
// valid bit. When rgb_stall holds back the result, stages upstream keep filling
// into any empty slots, so hsl_stall rises only once all seven stages are occupied.
// Nothing needs a clearing pass after reset.
module hsl_to_rgb_converter #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           hsl_valid,
  output logic           hsl_stall,
  input  hslc_pkg::hsl_t hsl,
  output logic           rgb_valid,
  input  logic           rgb_stall,
  output hslc_pkg::rgb_t rgb
);

  localparam int NS = 7;
  localparam int ZW = FRAC_BITS + 4;
  localparam int MW = FRAC_BITS + 5;
  localparam int FW = ZW + MW;
  localparam logic [MW-1:0] RECIP15 =
      MW'(((64'd1 << (FRAC_BITS + 8)) + 64'd14) / 64'd15);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [NS:1]   vld;
  logic [NS+1:1] adv;

  always_comb begin
    adv[NS+1] = !rgb_stall;
    for (int k = NS; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= hsl_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign hsl_stall = !adv[1];
  assign rgb_valid = vld[NS];

  // Stage 1: estimate the number of whole turns in the hue.
  logic [31:0] turn_prod;
  logic [13:0] steps1;
  logic [9:0]  lo1;
  logic [7:0]  turns1;
  logic [15:0] sat1, lum1;

  assign turn_prod = {18'b0, hsl.hue[23:10]} * {14'b0, hslc_pkg::HUE_RECIP_TURN};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      steps1 <= hsl.hue[23:10];
      lo1    <= hsl.hue[9:0];
      turns1 <= turn_prod[31:24];
      sat1   <= hsl.saturation;
      lum1   <= hsl.luminance;
    end
  end

  // Stage 2: wrap, split into sector and offset, and scale the offset.
  logic [13:0]        turn_steps;
  logic [13:0]        wrapped;
  hslc_pkg::hue_pos_t pos;
  logic [13:0]        offset;
  logic [FRAC_BITS+13:0] offset_scaled;
  logic [ZW-1:0]      z2;
  hslc_pkg::sector_t  sec2;
  logic [15:0]        sat2, lum2;

  always_comb begin
    turn_steps    = {6'b0, turns1} * hslc_pkg::HUE_STEPS_TURN_W;
    wrapped       = steps1 - turn_steps;
    pos           = hslc_pkg::hue_split(wrapped[6:0]);
    offset        = {pos.rem, lo1};
    offset_scaled = {offset, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      z2   <= offset_scaled[FRAC_BITS+13:10];
      sec2 <= pos.sector;
      sat2 <= sat1;
      lum2 <= lum1;
    end
  end

  // Stage 3: divide by fifteen through the reciprocal to get the fraction.
  logic [FW-1:0]        frac_prod;
  logic [FRAC_BITS-1:0] f3;
  hslc_pkg::sector_t    sec3;
  logic [15:0]          sat3, lum3;

  assign frac_prod = FW'(z2) * FW'(RECIP15);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      f3   <= frac_prod[FRAC_BITS+8 +: FRAC_BITS];
      sec3 <= sec2;
      sat3 <= sat2;
      lum3 <= lum2;
    end
  end

  // Pure hue ramp, fed straight into the channel pipelines.
  logic [FRAC_BITS:0] up, down, ramp_r, ramp_g, ramp_b;

  always_comb begin
    up   = {1'b0, f3};
    down = ONE - up;
    unique case (sec3)
      hslc_pkg::SEC_GREEN_UP: begin
        ramp_r = ONE;  ramp_g = up;   ramp_b = '0;
      end
      hslc_pkg::SEC_RED_DOWN: begin
        ramp_r = down; ramp_g = ONE;  ramp_b = '0;
      end
      hslc_pkg::SEC_BLUE_UP: begin
        ramp_r = '0;   ramp_g = ONE;  ramp_b = up;
      end
      hslc_pkg::SEC_GREEN_DOWN: begin
        ramp_r = '0;   ramp_g = down; ramp_b = ONE;
      end
      hslc_pkg::SEC_RED_UP: begin
        ramp_r = up;   ramp_g = '0;   ramp_b = ONE;
      end
      hslc_pkg::SEC_BLUE_DOWN: begin
        ramp_r = ONE;  ramp_g = '0;   ramp_b = down;
      end
      default: begin
        ramp_r = '0;   ramp_g = '0;   ramp_b = '0;
      end
    endcase
  end

  hslc_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk        (clk),
    .en         (adv[7:4]),
    .ramp       (ramp_r),
    .saturation (sat3),
    .luminance  (lum3),
    .level      (rgb.red)
  );

  hslc_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk        (clk),
    .en         (adv[7:4]),
    .ramp       (ramp_g),
    .saturation (sat3),
    .luminance  (lum3),
    .level      (rgb.green)
  );

  hslc_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk        (clk),
    .en         (adv[7:4]),
    .ramp       (ramp_b),
    .saturation (sat3),
    .luminance  (lum3),
    .level      (rgb.blue)
  );

  // An accepted beat always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    hsl_valid && !hsl_stall |=> vld[1])
    else $error("accepted beat did not enter the first stage");

  // Occupancy rises by one when a beat enters and none leaves.
  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    hsl_valid && !hsl_stall && !(rgb_valid && !rgb_stall)
      |=> $countones(vld) == $past($countones(vld)) + 1)
    else $error("pipeline lost or duplicated a beat on entry");

  // Occupancy falls by one when a beat leaves and none enters.
  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && !rgb_stall && !(hsl_valid && !hsl_stall)
      |=> $countones(vld) + 1 == $past($countones(vld)))
    else $error("pipeline lost or duplicated a beat on exit");

  // The input is held back only when every stage is occupied and the output waits.
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    hsl_stall |-> (&vld) && rgb_stall)
    else $error("input stalled while the pipeline had room");

endmodule

/* dv/tb_hsl_to_rgb_converter.sv */
// Self-checking testbench for hsl_to_rgb_converter: directed and random pixels, a
// bit-exact color predictor and a scoreboard, random idles and stalls on both sides.
// Depends on rtl/hslc_pkg.sv, rtl/hslc_chan.sv and rtl/hsl_to_rgb_converter.sv.
module tb_hsl_to_rgb_converter;

  localparam int FRAC_BITS      = 16;
  localparam int HUE_TURN       = 92160;  // 360 degrees with 8 fraction bits
  localparam int HUE_SECTOR_SPAN = 15360; // 60 degrees with 8 fraction bits
  localparam int RANDOM_PIXELS  = 650;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  class rgb_scoreboard #(int FRAC = 16);
    hslc_pkg::rgb_t rgb_due[$];
    int   mismatches;
    int   matched;

    function new();
      mismatches = 0;
      matched    = 0;
    endfunction

    // Bit-exact conversion of one pixel, done in 64-bit unsigned arithmetic.
    function hslc_pkg::rgb_t convert_hsl(hslc_pkg::hsl_t px);
      longint unsigned one, hr, f, lum, sat, v, acc, level;
      longint unsigned ramp[3];
      logic [15:0] chan[3];
      hslc_pkg::rgb_t  color;
      hslc_pkg::sector_t sec;
      one = 64'd1 << FRAC;
      lum = px.luminance;
      sat = px.saturation;
      hr  = px.hue;
      hr  = hr % HUE_TURN;
      sec = hslc_pkg::sector_t'(3'(hr / HUE_SECTOR_SPAN));
      f   = ((hr % HUE_SECTOR_SPAN) << FRAC) / HUE_SECTOR_SPAN;
      case (sec)
        hslc_pkg::SEC_GREEN_UP: begin
          ramp[0] = one;     ramp[1] = f;       ramp[2] = 0;
        end
        hslc_pkg::SEC_RED_DOWN: begin
          ramp[0] = one - f; ramp[1] = one;     ramp[2] = 0;
        end
        hslc_pkg::SEC_BLUE_UP: begin
          ramp[0] = 0;       ramp[1] = one;     ramp[2] = f;
        end
        hslc_pkg::SEC_GREEN_DOWN: begin
          ramp[0] = 0;       ramp[1] = one - f; ramp[2] = one;
        end
        hslc_pkg::SEC_RED_UP: begin
          ramp[0] = f;       ramp[1] = 0;       ramp[2] = one;
        end
        default: begin
          ramp[0] = one;     ramp[1] = 0;       ramp[2] = one - f;
        end
      endcase
      for (int i = 0; i < 3; i++) begin
        // Half luminance takes the darken path, which leaves the ramp as it is.
        if (lum <= hslc_pkg::HALF_LUM) begin
          v = (ramp[i] * lum) >> 15;
        end else begin
          v = ramp[i] + (((one - ramp[i]) * ((lum - hslc_pkg::HALF_LUM) * 2)) >> 16);
        end
        acc   = (v << (32 - FRAC)) * sat + lum * (65536 - sat) * 65536;
        level = (acc + (64'd1 << 31)) >> 32;
        chan[i] = (level > 65535) ? 16'hFFFF : 16'(level);
      end
      color.red   = chan[0];
      color.green = chan[1];
      color.blue  = chan[2];
      return color;
    endfunction

    function void note_pixel(hslc_pkg::hsl_t px);
      rgb_due.push_back(convert_hsl(px));
    endfunction

    function void check_rgb(hslc_pkg::rgb_t got);
      hslc_pkg::rgb_t want;
      if (rgb_due.size() == 0) begin
        $error("rgb beat with no pixel outstanding: %h", got);
        mismatches++;
        return;
      end
      want = rgb_due.pop_front();
      if (got.red !== want.red) begin
        $error("red: expected %0d, actual %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, actual %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, actual %0d", want.blue, got.blue);
        mismatches++;
      end
      matched++;
    endfunction

    function int outstanding();
      return rgb_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hsl_valid;
  logic hsl_stall;
  hslc_pkg::hsl_t hsl;
  logic rgb_valid;
  logic rgb_stall;
  hslc_pkg::rgb_t rgb;

  rgb_scoreboard #(FRAC_BITS) board;
  bit no_idle = 1'b0;
  int sent = 0;

  hsl_to_rgb_converter #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .hsl_valid (hsl_valid),
    .hsl_stall (hsl_stall),
    .hsl       (hsl),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic hslc_pkg::hsl_t make_pixel(int h, int s, int l);
    hslc_pkg::hsl_t px;
    px.hue        = 24'(h);
    px.saturation = 16'(s);
    px.luminance  = 16'(l);
    return px;
  endfunction

  function automatic logic [15:0] random_level();
    int levels[6] = '{0, 1, 32767, 32768, 32769, 65535};
    if ($urandom_range(99) < 15) begin
      return 16'(levels[$urandom_range(5)]);
    end
    return 16'($urandom);
  endfunction

  function automatic hslc_pkg::hsl_t random_pixel();
    hslc_pkg::hsl_t px;
    int pick;
    int base;
    pick = $urandom_range(9);
    if (pick < 4) begin
      px.hue = 24'($urandom);
    end else if (pick < 8) begin
      px.hue = 24'($urandom_range(HUE_TURN - 1));
    end else begin
      // Land within two hue LSBs of a sector edge, in any of turns 0 to 181.
      base = $urandom_range(5) * HUE_SECTOR_SPAN + $urandom_range(181) * HUE_TURN;
      px.hue = 24'(base + $urandom_range(4) - 2);
    end
    px.saturation = random_level();
    px.luminance  = random_level();
    return px;
  endfunction

  task automatic send_pixel(input hslc_pkg::hsl_t px);
    int gap;
    if (!no_idle && $urandom_range(99) < 8) begin
      hsl_valid <= 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(posedge clk);
    end
    hsl_valid <= 1'b1;
    hsl       <= px;
    @(posedge clk);
    while (hsl_stall) @(posedge clk);
    board.note_pixel(px);
    sent++;
  endtask

  // Hold the input side off until every outstanding color has come back.
  task automatic drain_pipeline();
    hsl_valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  // Result side: check each accepted beat, then pick the next stall.
  initial begin
    rgb_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rgb_valid && !rgb_stall) begin
        board.check_rgb(rgb);
      end
      rgb_stall <= !no_idle && ($urandom_range(99) < 8);
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((hsl_valid && !hsl_stall) || (rgb_valid && !rgb_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int directed;
    board     = new();
    rst       = 1'b1;
    hsl_valid = 1'b0;
    hsl       = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Every sector edge at full saturation and half luminance, then wraps.
    send_pixel(make_pixel(0, 65535, 32768));
    send_pixel(make_pixel(15360, 65535, 32768));
    send_pixel(make_pixel(30720, 65535, 32768));
    send_pixel(make_pixel(46080, 65535, 32768));
    send_pixel(make_pixel(61440, 65535, 32768));
    send_pixel(make_pixel(76800, 65535, 32768));
    send_pixel(make_pixel(92159, 65535, 32768));
    send_pixel(make_pixel(92160, 65535, 32768));
    send_pixel(make_pixel(16777215, 65535, 32769));
    // Grey, white and black corners, then both paths around the midpoint.
    send_pixel(make_pixel(7680, 0, 0));
    send_pixel(make_pixel(7680, 65535, 65535));
    send_pixel(make_pixel(7680, 65535, 0));
    send_pixel(make_pixel(23040, 32768, 16384));
    send_pixel(make_pixel(38400, 40000, 50000));
    send_pixel(make_pixel(53760, 65535, 32767));
    send_pixel(make_pixel(69120, 1, 32769));
    send_pixel(make_pixel(84480, 65535, 49152));
    send_pixel(make_pixel(0, 65535, 65535));
    send_pixel(make_pixel(12345, 0, 65535));
    send_pixel(make_pixel(46079, 65535, 40000));
    directed = sent;
    drain_pipeline();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      no_idle = (i >= 250 && i < 400);
      if (i == 500) begin
        drain_pipeline();
      end
      send_pixel(random_pixel());
    end
    no_idle = 1'b0;

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.outstanding() != 0) begin
      $error("%0d colors never came back", board.outstanding());
      board.mismatches++;
    end

    $display("Converted %0d pixels (%0d directed, %0d random), %0d colors checked.",
             sent, directed, sent - directed, board.matched);
    $display("Hues in all six sectors and past a full turn; grey to full saturation;");
    $display("dark and light.");
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
